/* rtl/core/hrng_pkg.sv */
// Package for the hexagonal ring neighbour generator.
// Holds the board constants, the stage types and the ring arithmetic helpers.
// No dependencies.
package hrng_pkg;

  localparam int MAX_RINGS   = 64;
  localparam int EDGES       = 6;
  localparam int NB_MAX      = 6;
  localparam int RING_W      = 6;
  localparam int POS_W       = 9;
  localparam int CELL_W      = 14;
  localparam int CNT_W       = 7;
  localparam int IDX_W       = 3;

  localparam logic [CNT_W-1:0] RING_COUNT_RST = CNT_W'(MAX_RINGS);

  // One neighbour waiting to be sent: ring, position and the first cell
  // number of its ring
  typedef struct packed {
    logic [RING_W-1:0] ring;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] base;
  } entry_t;

  // Decoded cell carried from the first stage to the second
  typedef struct packed {
    logic [RING_W-1:0] ring;
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  q;        // position divided by ring
    logic              corner;
    logic              bad;
    logic              outer;
    logic              centre_ok;
  } cell_t;

  // Number of cells on a ring, one for the centre
  function automatic logic [POS_W:0] ring_size(input logic [CNT_W-1:0] r);
    logic [POS_W:0] sz;
    sz = {{(POS_W+1-CNT_W){1'b0}}, r};
    if (r == '0) begin
      ring_size = (POS_W+1)'(1);
    end else begin
      ring_size = (sz << 2) + (sz << 1);
    end
  endfunction

  // First cell number of a ring: 1 + 3r(r-1), zero for the centre
  function automatic logic [CELL_W-1:0] ring_base(input logic [CNT_W-1:0] r);
    logic [CELL_W-1:0] rw;
    logic [CELL_W-1:0] prod;
    logic [CELL_W+1:0] trip;
    rw   = {{(CELL_W-CNT_W){1'b0}}, r};
    prod = rw * (rw - CELL_W'(1));
    trip = {2'b00, prod} + {1'b0, prod, 1'b0};
    if (r == '0) begin
      ring_base = '0;
    end else begin
      ring_base = CELL_W'(trip + (CELL_W+2)'(1));
    end
  endfunction

endpackage

/* rtl/core/hex_ring_neighbor_generator_unit.sv */
// Top level of the hexagonal ring neighbour generator.
// Three-stage pipeline plus output register; depends on hrng_pkg.
//
// Usage:
//   Input channel (in_valid, in_stall, in_ring, in_position) takes one cell in
//   ring coordinates per transaction. Result channel (out_valid, out_stall,
//   out_neighbor_*) returns its neighbours, one per transaction, in fixed
//   order, with out_last_neighbor high on the final one. An off-board cell
//   gives a single transaction with out_bad_cell set and zero fields; the
//   centre on a one-ring board gives none.
//   cfg_wr_en / cfg_wr_data write ring_count; write it only while idle.
//   The first result of a cell passes the decode and neighbour build stages,
//   the serialiser and the output register, in that order. The single result
//   port gives one result per cycle while out_stall is low; a cell has 0 to 6
//   results, six for a full cell, and a cell with no results takes no output
//   slot. While the serialiser drains, new cells are still accepted until
//   stages 1 and 2 are full.
//   Reset (rst_n low, synchronous) empties every stage and sets
//   ring_count to 64. A stall on the result side holds the output register
//   and backs the pipeline up stage by stage; nothing is lost or repeated.
module hex_ring_neighbor_generator_unit
  import hrng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RING_W-1:0] in_ring,
  input  logic [POS_W-1:0]  in_position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RING_W-1:0] out_neighbor_ring,
  output logic [POS_W-1:0]  out_neighbor_position,
  output logic [CELL_W-1:0] out_neighbor_cell,
  output logic              out_last_neighbor,
  output logic              out_bad_cell
);

  logic [CNT_W-1:0]  ring_count_r;
  logic [CNT_W-1:0]  eff_cnt;

  logic              s1_valid_r;
  logic [RING_W-1:0] s1_ring_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [POS_W-1:0]  s1_mult [0:7];
  logic [IDX_W-1:0]  s1_q;
  cell_t             s1_cell;

  logic              s2_valid_r;
  cell_t             s2_r;
  entry_t            s2_ent [0:NB_MAX-1];
  logic [IDX_W-1:0]  s2_n;

  logic              s3_valid_r;
  entry_t            s3_ent_r [0:NB_MAX-1];
  logic [IDX_W-1:0]  s3_n_r;
  logic [IDX_W-1:0]  s3_k_r;
  logic [IDX_W-1:0]  s3_k_nxt;
  logic              s3_bad_r;
  logic              s3_last;
  entry_t            s3_sel;

  logic              out_valid_r;
  logic [RING_W-1:0] out_ring_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CELL_W-1:0] out_cell_r;
  logic              out_last_r;
  logic              out_bad_r;

  logic              out_load;
  logic              s3_emit;
  logic              s3_take;
  logic              s2_go;
  logic              s2_take;
  logic              s1_take;

  // Hold the ring count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r <= RING_COUNT_RST;
    end else if (cfg_wr_en) begin
      ring_count_r <= cfg_wr_data;
    end
  end

  assign eff_cnt = (ring_count_r > CNT_W'(MAX_RINGS)) ? CNT_W'(MAX_RINGS) : ring_count_r;

  // Handshake between stages: each stage moves when the next one frees up
  assign out_load = !out_valid_r || !out_stall;
  assign s3_last  = (s3_k_r == s3_n_r - IDX_W'(1));
  assign s3_emit  = s3_valid_r && out_load;
  assign s3_take  = !s3_valid_r || (s3_emit && s3_last);
  assign s2_go    = s2_valid_r && ((s2_n == '0) || s3_take);
  assign s2_take  = !s2_valid_r || s2_go;
  assign s1_take  = !s1_valid_r || s2_take;
  assign in_stall = !s1_take;

  // Stage 1: capture the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_ring_r <= in_ring;
      s1_pos_r  <= in_position;
    end
  end

  // Stage 1 decode: multiples of the ring, sector index and corner test
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      s1_mult[k] = POS_W'(k * int'(s1_ring_r));
    end
    s1_q = '0;
    for (int k = 1; k < EDGES; k++) begin
      if (s1_pos_r >= s1_mult[k]) begin
        s1_q = s1_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    s1_cell.ring      = s1_ring_r;
    s1_cell.pos       = s1_pos_r;
    s1_cell.q         = s1_q;
    s1_cell.corner    = (s1_pos_r == s1_mult[s1_q]);
    s1_cell.bad       = ({1'b0, s1_ring_r} >= eff_cnt) ||
                        ({1'b0, s1_pos_r} >= ring_size({1'b0, s1_ring_r}));
    s1_cell.outer     = ({1'b0, s1_ring_r} + CNT_W'(1)) < eff_cnt;
    s1_cell.centre_ok = eff_cnt >= CNT_W'(2);
  end

  // Stage 2: hold the decoded cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_take) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid_r) begin
      s2_r <= s1_cell;
    end
  end

  // Stage 2 build: list the neighbours of the held cell
  always_comb begin
    logic [CNT_W-1:0]  r;
    logic [CNT_W-1:0]  rm;
    logic [CNT_W-1:0]  rp;
    logic [POS_W:0]    sz_r;
    logic [POS_W:0]    sz_m;
    logic [POS_W:0]    sz_p;
    logic [POS_W:0]    a;
    logic [POS_W:0]    ai;
    logic [POS_W:0]    ao;
    logic [POS_W-1:0]  prev_r;
    logic [POS_W-1:0]  next_r;
    logic [POS_W-1:0]  next_i;
    logic [POS_W-1:0]  prev_o;
    logic [POS_W-1:0]  next_o;
    logic [CELL_W-1:0] b_m;
    logic [CELL_W-1:0] b_r;
    logic [CELL_W-1:0] b_p;
    r      = {1'b0, s2_r.ring};
    rm     = r - CNT_W'(1);
    rp     = r + CNT_W'(1);
    sz_r   = ring_size(r);
    sz_m   = ring_size(rm);
    sz_p   = ring_size(rp);
    a      = {1'b0, s2_r.pos};
    ai     = a - (POS_W+1)'(s2_r.q) - (s2_r.corner ? '0 : (POS_W+1)'(1));
    ao     = a + (POS_W+1)'(s2_r.q);
    prev_r = POS_W'((a == '0) ? sz_r - (POS_W+1)'(1) : a - (POS_W+1)'(1));
    next_r = POS_W'((a + (POS_W+1)'(1) == sz_r) ? '0 : a + (POS_W+1)'(1));
    next_i = POS_W'((ai + (POS_W+1)'(1) == sz_m) ? '0 : ai + (POS_W+1)'(1));
    prev_o = POS_W'((ao == '0) ? sz_p - (POS_W+1)'(1) : ao - (POS_W+1)'(1));
    next_o = POS_W'((ao + (POS_W+1)'(1) == sz_p) ? '0 : ao + (POS_W+1)'(1));
    b_m    = ring_base(rm);
    b_r    = ring_base(r);
    b_p    = ring_base(rp);

    for (int i = 0; i < NB_MAX; i++) begin
      s2_ent[i] = '0;
    end
    s2_n = '0;

    if (s2_r.bad) begin
      // off the board: one empty result
      s2_n = IDX_W'(1);
    end else if (s2_r.ring == '0) begin
      // centre: the whole first ring, none on a one-ring board
      for (int i = 0; i < NB_MAX; i++) begin
        s2_ent[i].ring = RING_W'(1);
        s2_ent[i].pos  = POS_W'(i);
        s2_ent[i].base = ring_base(CNT_W'(1));
      end
      s2_n = s2_r.centre_ok ? IDX_W'(NB_MAX) : '0;
    end else if (s2_r.corner) begin
      s2_ent[0] = '{ring: RING_W'(rm), pos: POS_W'(ai), base: b_m};
      s2_ent[1] = '{ring: RING_W'(r),  pos: prev_r,     base: b_r};
      s2_ent[2] = '{ring: RING_W'(r),  pos: next_r,     base: b_r};
      s2_ent[3] = '{ring: RING_W'(rp), pos: prev_o,     base: b_p};
      s2_ent[4] = '{ring: RING_W'(rp), pos: POS_W'(ao), base: b_p};
      s2_ent[5] = '{ring: RING_W'(rp), pos: next_o,     base: b_p};
      s2_n = s2_r.outer ? IDX_W'(6) : IDX_W'(3);
    end else begin
      s2_ent[0] = '{ring: RING_W'(rm), pos: POS_W'(ai), base: b_m};
      s2_ent[1] = '{ring: RING_W'(rm), pos: next_i,     base: b_m};
      s2_ent[2] = '{ring: RING_W'(r),  pos: prev_r,     base: b_r};
      s2_ent[3] = '{ring: RING_W'(r),  pos: next_r,     base: b_r};
      s2_ent[4] = '{ring: RING_W'(rp), pos: POS_W'(ao), base: b_p};
      s2_ent[5] = '{ring: RING_W'(rp), pos: next_o,     base: b_p};
      s2_n = s2_r.outer ? IDX_W'(6) : IDX_W'(4);
    end
  end

  // Stage 3: serialiser, load a list when the previous one is done
  always_comb begin
    s3_k_nxt = s3_k_r;
    if (s3_take) begin
      s3_k_nxt = '0;
    end else if (s3_emit) begin
      s3_k_nxt = s3_k_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s3_k_r     <= '0;
    end else begin
      s3_k_r <= s3_k_nxt;
      if (s3_take) begin
        s3_valid_r <= s2_valid_r && (s2_n != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_take && s2_valid_r) begin
      s3_ent_r <= s2_ent;
      s3_n_r   <= s2_n;
      s3_bad_r <= s2_r.bad;
    end
  end

  // Pick the current neighbour
  always_comb begin
    s3_sel = s3_ent_r[0];
    for (int i = 1; i < NB_MAX; i++) begin
      if (s3_k_r == IDX_W'(i)) begin
        s3_sel = s3_ent_r[i];
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_emit) begin
      out_ring_r <= s3_sel.ring;
      out_pos_r  <= s3_sel.pos;
      out_cell_r <= s3_sel.base + CELL_W'(s3_sel.pos);
      out_last_r <= s3_last;
      out_bad_r  <= s3_bad_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_neighbor_ring     = out_ring_r;
  assign out_neighbor_position = out_pos_r;
  assign out_neighbor_cell     = out_cell_r;
  assign out_last_neighbor     = out_last_r;
  assign out_bad_cell          = out_bad_r;

  // Checks on the serialiser and the error result
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_k_r < s3_n_r))
    else $error("serialiser index past the end of its list");

  a_no_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_n_r != '0))
    else $error("serialiser holds an empty list");

  a_bad_is_lone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_last_r && (out_cell_r == '0) && (out_pos_r == '0)))
    else $error("error result not a lone zero transaction");

  a_last_closes_list: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_emit && s3_last) |=> (out_valid_r && out_last_r))
    else $error("final neighbour not flagged as last");

endmodule

/* tb/tb.sv */
// Testbench for hex_ring_neighbor_generator_unit: directed and random cells, checked
// transaction by transaction against a behavioural neighbour predictor.
// Depends on hrng_pkg and the unit itself.
module tb;
  import hrng_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 80;
  localparam int MAX_REPORTS  = 30;
  localparam int TIME_LIMIT   = 4_000_000;

  typedef struct packed {
    logic [RING_W-1:0] ring;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] lin_no;
    logic              last;
    logic              bad;
  } neighbour_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [RING_W-1:0] in_ring;
  logic [POS_W-1:0]  in_position;
  logic              out_valid;
  logic              out_stall;
  logic [RING_W-1:0] out_neighbor_ring;
  logic [POS_W-1:0]  out_neighbor_position;
  logic [CELL_W-1:0] out_neighbor_cell;
  logic              out_last_neighbor;
  logic              out_bad_cell;

  // Neighbours still owed by the unit, oldest first
  neighbour_t       pending_neighbours[$];
  logic [CNT_W-1:0] board_rings;

  int   errors;
  int   cells_sent;
  int   results_seen;
  int   bad_seen;
  int   settings_written;
  int   stall_pct;
  int   run_left;
  int   hold_count;
  logic run_stall;
  logic hold_request;
  logic hold_active;

  hex_ring_neighbor_generator_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_ring               (in_ring),
    .in_position           (in_position),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_neighbor_ring     (out_neighbor_ring),
    .out_neighbor_position (out_neighbor_position),
    .out_neighbor_cell     (out_neighbor_cell),
    .out_last_neighbor     (out_last_neighbor),
    .out_bad_cell          (out_bad_cell)
  );

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Ring arithmetic for the predictor
  function automatic int unsigned cells_on_ring(input int unsigned r);
    return (r != 0) ? r * EDGES : 1;
  endfunction

  function automatic int unsigned step_fwd(input int unsigned r, input int unsigned a);
    return (a + 1 < cells_on_ring(r)) ? a + 1 : 0;
  endfunction

  function automatic int unsigned step_back(input int unsigned r, input int unsigned a);
    return (a != 0) ? a - 1 : cells_on_ring(r) - 1;
  endfunction

  function automatic neighbour_t make_neighbour(input int unsigned r, input int unsigned a);
    neighbour_t nb;
    int unsigned lin;
    lin = (r != 0) ? 1 + 3 * r * (r - 1) + a : 0;
    nb.ring   = RING_W'(r);
    nb.pos    = POS_W'(a);
    nb.lin_no = CELL_W'(lin);
    nb.last   = 1'b0;
    nb.bad    = 1'b0;
    return nb;
  endfunction

  // Append one neighbour to the owed list
  function automatic void owe_neighbour(input neighbour_t nb);
    pending_neighbours = {pending_neighbours, nb};
  endfunction

  // Work out the neighbours of one accepted cell and queue them
  function automatic void predict_neighbours(input logic [RING_W-1:0] r_in,
                                             input logic [POS_W-1:0] a_in);
    neighbour_t  found[6];
    neighbour_t  off_board;
    int unsigned r, a, cnt, ai, ao;
    int          k, i;
    r   = r_in;
    a   = a_in;
    cnt = (board_rings < MAX_RINGS) ? board_rings : MAX_RINGS;
    k   = 0;
    if (r >= cnt || a >= cells_on_ring(r)) begin
      off_board = '0;
      off_board.last = 1'b1;
      off_board.bad  = 1'b1;
      owe_neighbour(off_board);
      return;
    end
    if (r == 0) begin
      // Centre: all of ring 1, unless the board is a single ring
      if (cnt >= 2) begin
        for (i = 0; i < EDGES; i++) begin
          found[i] = make_neighbour(1, i);
        end
        k = EDGES;
      end
    end else begin
      ai = (a * (r - 1)) / r;
      ao = (a * (r + 1)) / r;
      if (a % r == 0) begin
        found[0] = make_neighbour(r - 1, ai);
        found[1] = make_neighbour(r, step_back(r, a));
        found[2] = make_neighbour(r, step_fwd(r, a));
        k = 3;
        if (r + 1 < cnt) begin
          found[3] = make_neighbour(r + 1, step_back(r + 1, ao));
          found[4] = make_neighbour(r + 1, ao);
          found[5] = make_neighbour(r + 1, step_fwd(r + 1, ao));
          k = 6;
        end
      end else begin
        found[0] = make_neighbour(r - 1, ai);
        found[1] = make_neighbour(r - 1, step_fwd(r - 1, ai));
        found[2] = make_neighbour(r, step_back(r, a));
        found[3] = make_neighbour(r, step_fwd(r, a));
        k = 4;
        if (r + 1 < cnt) begin
          found[4] = make_neighbour(r + 1, ao);
          found[5] = make_neighbour(r + 1, step_fwd(r + 1, ao));
          k = 6;
        end
      end
    end
    if (k > 0) begin
      found[k-1].last = 1'b1;
    end
    for (i = 0; i < k; i++) begin
      owe_neighbour(found[i]);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  // Compare each result transaction with the oldest pending neighbour
  always @(posedge clk) begin : result_check
    neighbour_t got;
    neighbour_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_neighbor_ring, out_neighbor_position, out_neighbor_cell,
             out_last_neighbor, out_bad_cell};
      results_seen++;
      if (out_bad_cell) begin
        bad_seen++;
      end
      if (pending_neighbours.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
        end
      end else begin
        want = pending_neighbours.pop_front();
        check_field("neighbor_ring", want.ring, got.ring);
        check_field("neighbor_position", want.pos, got.pos);
        check_field("neighbor_cell", want.lin_no, got.lin_no);
        check_field("last_neighbor", want.last, got.last);
        check_field("bad_cell", want.bad, got.bad);
      end
    end
  end

  // Receiver: random stall runs, or a long hold-off on request
  initial begin : receiver
    out_stall   = 1'b0;
    hold_active = 1'b0;
    run_left    = 0;
    run_stall   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall   <= 1'b1;
        hold_active <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
          @(posedge clk);
        end
        hold_active <= 1'b0;
        out_stall   <= 1'b0;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        run_left  = $urandom_range(0, 5);
        run_stall = ($urandom_range(1, 100) <= stall_pct);
        out_stall <= run_stall;
      end
    end
  end

  // Offer one cell and hold it until the unit takes it
  task automatic send_cell(input logic [RING_W-1:0] r, input logic [POS_W-1:0] a);
    in_valid    <= 1'b1;
    in_ring     <= r;
    in_position <= a;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_neighbours(r, a);
    cells_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every owed neighbour has come, then idle for DRAIN_CYCLES
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_neighbours.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ring_count(input logic [CNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board_rings = value;
    settings_written++;
  endtask

  // Mostly cells on the board, corners favoured, with some off-board noise
  task automatic pick_cell(output logic [RING_W-1:0] r, output logic [POS_W-1:0] a);
    int unsigned cnt, rr, roll;
    cnt  = (board_rings < MAX_RINGS) ? board_rings : MAX_RINGS;
    roll = $urandom_range(0, 99);
    if (cnt == 0 || roll < 12) begin
      r = RING_W'($urandom_range(0, 63));
      a = POS_W'($urandom_range(0, 511));
    end else begin
      rr = $urandom_range(0, cnt - 1);
      r  = RING_W'(rr);
      if (rr == 0) begin
        a = '0;
      end else if (roll < 18) begin
        a = POS_W'(EDGES * rr + $urandom_range(0, 3));
      end else if (roll < 45) begin
        a = POS_W'(rr * $urandom_range(0, 5));
      end else begin
        a = POS_W'($urandom_range(0, EDGES * rr - 1));
      end
    end
  endtask

  task automatic run_random_phase(input logic [CNT_W-1:0] rings, input int n_cells,
                                  input int pct);
    logic [RING_W-1:0] r;
    logic [POS_W-1:0]  a;
    int                burst, i;
    wait_drained();
    write_ring_count(rings);
    stall_pct <= pct;
    burst = $urandom_range(1, 12);
    for (i = 0; i < n_cells; i++) begin
      pick_cell(r, a);
      send_cell(r, a);
      burst--;
      if (burst == 0) begin
        // No gaps in phases without receiver stalls, to keep some full-rate stretches
        if (pct != 0) begin
          pause_sender($urandom_range(1, 6));
        end
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  // Corners, edges, wrap points, last ring and off-board cells on the reset board
  task automatic test_full_board();
    stall_pct <= 25;
    send_cell(0, 0);
    send_cell(1, 0);
    send_cell(1, 5);
    send_cell(2, 1);
    send_cell(2, 11);
    send_cell(3, 6);
    send_cell(5, 29);
    send_cell(62, 0);
    send_cell(62, 371);
    send_cell(63, 0);
    send_cell(63, 377);
    send_cell(63, 200);
    send_cell(4, 24);
    send_cell(0, 1);
    send_cell(0, 511);
    send_cell(63, 378);
    send_cell(42, 511);
  endtask

  // Empty, single-ring, two-ring and oversized boards
  task automatic test_small_boards();
    wait_drained();
    write_ring_count(0);
    send_cell(0, 0);
    send_cell(1, 0);
    wait_drained();
    write_ring_count(1);
    send_cell(0, 0);
    send_cell(1, 3);
    wait_drained();
    write_ring_count(2);
    send_cell(0, 0);
    send_cell(1, 2);
    wait_drained();
    write_ring_count(127);
    send_cell(63, 0);
    send_cell(63, 150);
  endtask

  task automatic test_random_traffic();
    run_random_phase(64, 30, 30);
    run_random_phase(127, 25, 0);
    run_random_phase(CNT_W'($urandom_range(3, 63)), 25, 50);
    run_random_phase(2, 20, 20);
    run_random_phase(CNT_W'($urandom_range(1, 127)), 30, 40);
    run_random_phase(64, 27, 70);
  endtask

  // Hold the receiver off while cells keep coming, then drain and restart
  task automatic test_backpressure();
    logic [RING_W-1:0] r;
    logic [POS_W-1:0]  a;
    int                i;
    wait_drained();
    write_ring_count(64);
    stall_pct <= 0;
    hold_request <= 1'b1;
    while (!hold_active) begin
      @(posedge clk);
    end
    hold_request <= 1'b0;
    for (i = 0; i < 20; i++) begin
      pick_cell(r, a);
      send_cell(r, a);
    end
    wait_drained();
    stall_pct <= 35;
    for (i = 0; i < 8; i++) begin
      pick_cell(r, a);
      send_cell(r, a);
    end
  endtask

  // Stimulus and final verdict
  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_ring          = '0;
    in_position      = '0;
    hold_request     = 1'b0;
    stall_pct        = 0;
    board_rings      = RING_COUNT_RST;
    errors           = 0;
    cells_sent       = 0;
    results_seen     = 0;
    bad_seen         = 0;
    settings_written = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_board();
    test_small_boards();
    test_random_traffic();
    test_backpressure();
    wait_drained();

    $display("Covered %0d cells giving %0d neighbour transactions (%0d off-board)",
             cells_sent, results_seen, bad_seen);
    $display("over %0d ring-count settings, with random stalls and a long receiver hold-off",
             settings_written);
    if (errors == 0 && pending_neighbours.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIME_LIMIT);
    $display("%0t: timeout with %0d neighbours outstanding", $time,
             pending_neighbours.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/core/hrng_pkg.sv
rtl/core/hex_ring_neighbor_generator_unit.sv
tb/tb.sv
